// ===== src/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants of the bitmap membership set.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int WORD_COUNT_DEF = 64;

    localparam int ENTITY_W   = 16;
    localparam int CFG_W      = 7;
    localparam int COUNT_W    = 12;
    localparam int ACTIVE_MAX = 127;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 12'hFFF;
    localparam logic [CFG_W-1:0]   ACTIVE_RESET = 7'd64;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_TEST   = 3'd2;
    localparam logic [2:0] MODE_COPY   = 3'd3;
    localparam logic [2:0] MODE_START  = 3'd4;
    localparam logic [2:0] MODE_NEXT   = 3'd5;

    typedef struct packed {
        logic [2:0]          mode;
        logic [ENTITY_W-1:0] entity;
        logic [ENTITY_W-1:0] source_entity;
    } in_item_t;

    typedef struct packed {
        logic                present;
        logic [COUNT_W-1:0]  member_count;
        logic [ENTITY_W-1:0] iter_entity;
        logic                iter_valid;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/bms_store.sv =====
// ----------------------------------------------------------------------------
// bms_store
// Membership word memory: one write port, two synchronous read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_store #(
    parameter int   WORD_BITS  = bms_pkg::WORD_BITS_DEF,
    parameter int   WORD_COUNT = bms_pkg::WORD_COUNT_DEF,
    localparam int  ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]    rd_addr_a,
    input  logic [ADDR_W-1:0]    rd_addr_b,
    output logic [WORD_BITS-1:0] rd_data_a,
    output logic [WORD_BITS-1:0] rd_data_b
);

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== src/bms_locate.sv =====
// ----------------------------------------------------------------------------
// bms_locate
// Splits an entity number into word index and bit position.
// Quotient estimate by reciprocal multiply, registered, then one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_locate #(
    parameter int  WORD_BITS = bms_pkg::WORD_BITS_DEF,
    localparam int BIT_W     = $clog2(WORD_BITS)
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [bms_pkg::ENTITY_W-1:0]  entity_in,
    output logic [bms_pkg::ENTITY_W-1:0]  word_out,
    output logic [BIT_W-1:0]              bit_out
);
    import bms_pkg::*;

    // floor reciprocal; estimate is exact or one low for any 16-bit entity
    localparam int SHIFT  = ENTITY_W + BIT_W;
    localparam int PROD_W = ENTITY_W + SHIFT;
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << SHIFT) / WORD_BITS);

    logic [ENTITY_W-1:0] ent_reg;
    logic [ENTITY_W-1:0] q_est_reg;
    logic [PROD_W-1:0]   prod;
    logic [ENTITY_W-1:0] rem;
    logic                fix;

    assign prod = PROD_W'(entity_in) * RECIP;

    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg   <= entity_in;
            q_est_reg <= prod[SHIFT +: ENTITY_W];
        end
    end

    always_comb begin
        rem      = ent_reg - q_est_reg * ENTITY_W'(WORD_BITS);
        fix      = (rem >= ENTITY_W'(WORD_BITS));
        word_out = q_est_reg + ENTITY_W'(fix);
        bit_out  = fix ? BIT_W'(rem - ENTITY_W'(WORD_BITS)) : BIT_W'(rem);
    end

endmodule

`default_nettype wire

// ===== src/bitmap_membership_set.sv =====
// ----------------------------------------------------------------------------
// bitmap_membership_set
// Bit-per-entity membership set with counted add/remove/copy/test and an
// ascending iterator that skips empty words.
// ----------------------------------------------------------------------------
// Result path after accept: ST_ADDR (locate+read), then ST_RMW (modify/write).
// Iterator start/next: passes through ST_SCAN, reading a further word each time, while skipping.
// A new transaction is accepted only once the previous one finishes and its result is loaded.
// Reset: clearing pass over all WORD_COUNT words, s_ready low; config ready always.
// active_words resets to 64; member count zero, iterator invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_membership_set #(
    parameter int WORD_BITS  = bms_pkg::WORD_BITS_DEF,
    parameter int WORD_COUNT = bms_pkg::WORD_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bms_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bms_pkg::out_item_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bms_pkg::CFG_W-1:0]  cfg_wdata
);
    import bms_pkg::*;

    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int ADDR_W   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int EFF_MAX  = (WORD_COUNT < ACTIVE_MAX) ? WORD_COUNT : ACTIVE_MAX;
    localparam int SCAN_W   = $clog2(EFF_MAX + 1);
    localparam int SCAN_RST = (int'(ACTIVE_RESET) < WORD_COUNT) ? int'(ACTIVE_RESET)
                                                                 : WORD_COUNT;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ADDR  = 6'b000100,
        ST_RMW   = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    in_item_t             item_reg;
    logic [ADDR_W-1:0]    clr_idx_reg;
    logic [CFG_W-1:0]     active_reg;
    logic [WORD_BITS-1:0] pending_reg, pending_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 present_reg, present_next;
    logic                 m_valid_reg;
    out_item_t            m_data_reg, result;

    logic [ENTITY_W-1:0]  dst_word, src_word;
    logic [BIT_W-1:0]     dst_bit, src_bit;
    logic [WORD_BITS-1:0] rd_a, rd_b;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, rd_addr_a, rd_addr_b;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [SCAN_W-1:0]    eff;
    logic                 dst_ok, src_ok, dst_val, src_val, wr_val;
    logic                 bit_write, iter_ok;
    logic [WORD_BITS-1:0] pend0;
    logic [SCAN_W-1:0]    scan0, scan_inc;
    logic                 skip_ok, do_skip, go_scan;
    logic                 fin, out_free, out_load, in_accept;

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    bms_locate #(.WORD_BITS(WORD_BITS)) u_loc_dst (
        .aclk      (aclk),
        .load      (in_accept),
        .entity_in (s_data.entity),
        .word_out  (dst_word),
        .bit_out   (dst_bit)
    );

    bms_locate #(.WORD_BITS(WORD_BITS)) u_loc_src (
        .aclk      (aclk),
        .load      (in_accept),
        .entity_in (s_data.source_entity),
        .word_out  (src_word),
        .bit_out   (src_bit)
    );

    bms_store #(.WORD_BITS(WORD_BITS), .WORD_COUNT(WORD_COUNT)) u_store (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign eff = (int'(active_reg) < WORD_COUNT) ? SCAN_W'(active_reg) : SCAN_W'(WORD_COUNT);

    assign dst_ok  = dst_word < ENTITY_W'(eff);
    assign src_ok  = src_word < ENTITY_W'(eff);
    assign dst_val = rd_a[dst_bit];
    assign src_val = src_ok && rd_b[src_bit];
    assign iter_ok = (scan_reg < eff) && (pending_reg != '0);

    always_comb begin
        pend0        = pending_reg;
        scan0        = scan_reg;
        skip_ok      = 1'b0;
        present_next = present_reg;
        count_next   = count_reg;
        wr_val       = 1'b0;
        bit_write    = 1'b0;
        if (state_reg == ST_RMW) begin
            present_next = 1'b0;
            unique case (item_reg.mode)
                MODE_ADD: begin
                    wr_val    = 1'b1;
                    bit_write = dst_ok && !dst_val;
                end
                MODE_REMOVE: begin
                    wr_val    = 1'b0;
                    bit_write = dst_ok && dst_val;
                end
                MODE_TEST: begin
                    present_next = dst_ok && dst_val;
                end
                MODE_COPY: begin
                    wr_val    = src_val;
                    bit_write = dst_ok && (dst_val != src_val);
                end
                MODE_START: begin
                    pend0   = (eff != '0) ? rd_a : '0;
                    scan0   = '0;
                    skip_ok = 1'b1;
                end
                MODE_NEXT: begin
                    if (iter_ok) begin
                        pend0   = pending_reg & (pending_reg - 1'b1);
                        skip_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (bit_write) begin
                if (wr_val) begin
                    count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
                end else begin
                    count_next = (count_reg == '0) ? count_reg : count_reg - 1'b1;
                end
            end
        end else if (state_reg == ST_SCAN) begin
            // read data is the word at scan_reg
            pend0   = rd_a;
            skip_ok = 1'b1;
        end
        do_skip      = skip_ok && (pend0 == '0) && (scan0 < eff);
        scan_inc     = scan0 + 1'b1;
        go_scan      = do_skip && (scan_inc < eff);
        pending_next = pend0;
        scan_next    = do_skip ? scan_inc : scan0;
    end

    always_comb begin
        result.present      = present_next;
        result.member_count = count_next;
        result.iter_valid   = (scan_next < eff) && (pending_next != '0);
        result.iter_entity  = result.iter_valid
            ? ENTITY_W'(int'(scan_next) * WORD_BITS + int'(low_bit(pending_next)))
            : '0;
    end

    // memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(dst_word);
        mem_wdata = rd_a ^ (WORD_BITS'(1) << dst_bit);
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_RMW) begin
            mem_we = bit_write;
        end
        if (state_reg == ST_ADDR) begin
            rd_addr_a = (item_reg.mode == MODE_START) ? '0 : ADDR_W'(dst_word);
        end else begin
            rd_addr_a = ADDR_W'(scan_inc);
        end
        rd_addr_b = ADDR_W'(src_word);
    end

    assign fin       = ((state_reg == ST_RMW || state_reg == ST_SCAN) && !go_scan)
                       || (state_reg == ST_HOLD);
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = fin && out_free;
    assign s_ready   = (state_reg == ST_IDLE) || out_load;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == ADDR_W'(WORD_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_ADDR;
            end
            ST_ADDR: begin
                state_next = ST_RMW;
            end
            ST_RMW, ST_SCAN, ST_HOLD: begin
                if (go_scan) begin
                    state_next = ST_SCAN;
                end else if (!out_free) begin
                    state_next = ST_HOLD;
                end else begin
                    state_next = s_valid ? ST_ADDR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            active_reg  <= ACTIVE_RESET;
            pending_reg <= '0;
            scan_reg    <= SCAN_W'(SCAN_RST);
            count_reg   <= '0;
            present_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_valid) begin
                active_reg <= cfg_wdata;
            end
            if (state_reg == ST_RMW || state_reg == ST_SCAN) begin
                pending_reg <= pending_next;
                scan_reg    <= scan_next;
                count_reg   <= count_next;
                present_reg <= present_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_RMW))
        else $error("memory write outside clear or read-modify-write");

    a_count_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RMW) |=> $stable(count_reg))
        else $error("member count changed outside read-modify-write");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transaction");

    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(state_reg == ST_CLEAR || state_reg == ST_ADDR || go_scan))
        else $error("input ready while store busy");

    a_iter_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.iter_valid) |-> (m_data_reg.iter_entity == '0))
        else $error("iterator entity nonzero without a position");

endmodule

`default_nettype wire

// ===== tb/bms_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bms_checker
// Watches the item, result and register channels of the bitmap membership
// set, keeps its own copy of the membership words and the iterator, and
// compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------

module bms_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  bms_pkg::in_item_t         s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  bms_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [bms_pkg::CFG_W-1:0] cfg_wdata,
    output int                        mismatches,
    output int                        outstanding,
    output int                        checked
);
    import bms_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam int WC = WORD_COUNT_DEF;

    logic [WB-1:0]    member_words [WC];
    logic [WB-1:0]    scan_bits;
    int               scan_idx;
    int               held;
    logic [CFG_W-1:0] limit_cfg;
    out_item_t        expected_q [$];
    out_item_t        want;
    int               fails;

    assign mismatches = fails;

    function automatic int words_in_use();
        return (limit_cfg < WC) ? int'(limit_cfg) : WC;
    endfunction

    function automatic bit in_limit(int unsigned e);
        return (e / WB) < words_in_use();
    endfunction

    function automatic bit read_member(int unsigned e);
        if (!in_limit(e))
            return 1'b0;
        return member_words[e / WB][e % WB];
    endfunction

    // count moves only on an actual flip, clamped to the 12-bit range
    function automatic void write_member(int unsigned e, bit v);
        if (!in_limit(e))
            return;
        if (v && !member_words[e / WB][e % WB]) begin
            member_words[e / WB][e % WB] = 1'b1;
            if (held < int'(COUNT_MAX))
                held++;
        end else if (!v && member_words[e / WB][e % WB]) begin
            member_words[e / WB][e % WB] = 1'b0;
            if (held > 0)
                held--;
        end
    endfunction

    function automatic void skip_empty_words();
        int lim;
        lim = words_in_use();
        while (scan_bits == '0 && scan_idx < lim) begin
            scan_idx++;
            if (scan_idx < lim)
                scan_bits = member_words[scan_idx];
        end
    endfunction

    function automatic int lowest_set(logic [WB-1:0] v);
        for (int i = 0; i < WB; i++)
            if (v[i])
                return i;
        return 0;
    endfunction

    function automatic out_item_t apply_item(in_item_t it);
        out_item_t res;
        bit        pres;
        bit        ok;
        pres = 1'b0;
        case (it.mode)
            MODE_ADD:    write_member(it.entity, 1'b1);
            MODE_REMOVE: write_member(it.entity, 1'b0);
            MODE_TEST:   pres = read_member(it.entity);
            MODE_COPY:   write_member(it.entity, read_member(it.source_entity));
            MODE_START: begin
                scan_idx = 0;
                scan_bits = (words_in_use() > 0) ? member_words[0] : '0;
                if (words_in_use() > 0)
                    skip_empty_words();
            end
            MODE_NEXT: begin
                if (scan_idx < words_in_use() && scan_bits != '0) begin
                    scan_bits = scan_bits & (scan_bits - 1'b1);
                    skip_empty_words();
                end
            end
            default: ;
        endcase
        ok = scan_idx < words_in_use() && scan_bits != '0;
        res.present      = pres;
        res.member_count = COUNT_W'(held);
        res.iter_entity  = ok ? ENTITY_W'(scan_idx * WB + lowest_set(scan_bits)) : '0;
        res.iter_valid   = ok;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WC; i++)
                member_words[i] = '0;
            limit_cfg = ACTIVE_RESET;
            scan_bits = '0;
            scan_idx = words_in_use();
            held = 0;
            expected_q.delete();
            fails = 0;
            checked = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                limit_cfg = cfg_wdata;
            if (s_valid && s_ready)
                expected_q.push_back(apply_item(s_data));
            if (m_valid && m_ready) begin
                checked++;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result transaction %h", $realtime, m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: result mismatch: expected present=%0d count=%0d ",
                                      "iter=%0d/%0d, got present=%0d count=%0d iter=%0d/%0d"},
                                     $realtime, want.present, want.member_count,
                                     want.iter_entity, want.iter_valid, m_data.present,
                                     m_data.member_count, m_data.iter_entity,
                                     m_data.iter_valid);
                    end
                end
            end
            // registered so the stimulus side always sees the pre-edge value
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/bitmap_membership_set_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_membership_set_test
// Drives directed and random set/clear/test/copy/iterate transactions into
// the bitmap membership set under several word limits, with random stalls on
// both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------

module bitmap_membership_set_test;
    import bms_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASES        = 7;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int checked;
    int items_sent;
    int cur_words;
    bit idle_en;
    bit hold_req;

    logic [CFG_W-1:0] phase_limit [PHASES] = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd1, 7'd40, 7'd64};
    int               phase_items [PHASES] = '{280, 60, 250, 200, 160, 250, 300};

    bitmap_membership_set u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    bms_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic in_item_t mk(logic [2:0] m, int unsigned e, int unsigned src);
        in_item_t it;
        it.mode = m;
        it.entity = ENTITY_W'(e);
        it.source_entity = ENTITY_W'(src);
        return it;
    endfunction

    // biased toward a few hot words so some words stay dense and others empty
    function automatic logic [ENTITY_W-1:0] pick_entity(int words);
        int r;
        int w;
        r = $urandom_range(0, 99);
        if (words == 0 || r < 8)
            return ENTITY_W'($urandom);
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: w = 0;
                1: w = 5;
                2: w = 6;
                3: w = 31;
                default: w = 63;
            endcase
            return ENTITY_W'((w % words) * 32 + $urandom_range(0, 31));
        end
        if (r < 60)
            return ENTITY_W'(words * 32 + $urandom_range(0, 95));
        return ENTITY_W'($urandom_range(0, words * 32 - 1));
    endfunction

    function automatic in_item_t random_op(int words);
        int         r;
        logic [2:0] m;
        in_item_t   it;
        r = $urandom_range(0, 99);
        if (r < 30)      m = MODE_ADD;
        else if (r < 45) m = MODE_REMOVE;
        else if (r < 60) m = MODE_TEST;
        else if (r < 72) m = MODE_COPY;
        else if (r < 78) m = MODE_START;
        else if (r < 95) m = MODE_NEXT;
        else if (r < 98) m = MODE_SPARE_LO;
        else             m = MODE_SPARE_HI;
        it = mk(m, $urandom, $urandom);
        if (m == MODE_ADD || m == MODE_REMOVE || m == MODE_TEST || m == MODE_COPY)
            it.entity = pick_entity(words);
        if (m == MODE_COPY)
            it.source_entity = pick_entity(words);
        return it;
    endfunction

    task automatic send(input in_item_t it);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] v);
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_words = (v < 64) ? int'(v) : 64;
    endtask

    task automatic run_directed();
        send(mk(MODE_TEST, 0, 0));
        send(mk(MODE_ADD, 0, 65535));
        send(mk(MODE_ADD, 0, 0));           // already set, count holds
        send(mk(MODE_ADD, 2047, 0));        // last entity in range
        send(mk(MODE_ADD, 2048, 0));        // beyond the limit, ignored
        send(mk(MODE_TEST, 2048, 0));
        send(mk(MODE_TEST, 65535, 65535));
        send(mk(MODE_ADD, 100, 0));
        send(mk(MODE_START, 0, 0));
        send(mk(MODE_NEXT, 0, 0));          // skips empty words 1..2
        send(mk(MODE_NEXT, 0, 0));
        send(mk(MODE_NEXT, 0, 0));          // runs off the end
        send(mk(MODE_NEXT, 65535, 65535));  // no position
        send(mk(MODE_COPY, 5, 100));
        send(mk(MODE_COPY, 100, 3000));     // out-of-range source reads 0
        send(mk(MODE_COPY, 65535, 0));      // out-of-range destination
        send(mk(MODE_TEST, 100, 0));
        send(mk(MODE_REMOVE, 2047, 0));
        send(mk(MODE_REMOVE, 2047, 0));
        send(mk(MODE_SPARE_LO, 0, 0));
        send(mk(MODE_SPARE_HI, 65535, 65535));
        send(mk(MODE_START, 0, 0));
        send(mk(MODE_ADD, 1, 0));           // current word was captured at start
        send(mk(MODE_NEXT, 0, 0));
        send(mk(MODE_NEXT, 0, 0));
    endtask

    task automatic run_random(input int n);
        int       sent;
        int       burst;
        in_item_t it;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 15) begin
                send(mk(MODE_START, $urandom, $urandom));
                sent++;
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                                    : $urandom_range(1, 20);
                for (int k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        it = random_op(cur_words);
                    else
                        it = mk(MODE_NEXT, $urandom, $urandom);
                    send(it);
                    sent++;
                end
            end else begin
                it = random_op(cur_words);
                send(it);
                if (it.mode != MODE_SPARE_LO && it.mode != MODE_SPARE_HI)
                    sent++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_wdata = '0;
        items_sent = 0;
        cur_words = 64;
        idle_en = 1'b1;
        hold_req = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            idle_en = (p != PHASES - 1);
            set_limit(phase_limit[p]);
            if (p == 0) begin
                run_directed();
                hold_req = 1'b1;
            end
            run_random(phase_items[p]);
        end

        drain();
        repeat (100) @(posedge aclk);

        $display("summary: %0d transactions over %0d word limits (0 to 127), %0d results checked",
                 items_sent, PHASES, checked);
        $display("summary: set/clear/test/copy, iterator start/next, unused modes, long stall");
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bms_pkg.sv
src/bms_store.sv
src/bms_locate.sv
src/bitmap_membership_set.sv
tb/bms_checker.sv
tb/bitmap_membership_set_test.sv
